@@ rtl/gpibdh_pkg.sv @@
// Package for the GPIB device handshake: payload structs, phase codes,
// role and command codes, and register indexes.
// No dependencies; gpib_device_handshake imports it.
`timescale 1ns / 1ps

package gpibdh_pkg;

  // Configuration register widths and reset values.
  localparam int unsigned DevAddrW    = 4;
  localparam int unsigned BlockBytesW = 10;
  localparam int unsigned DefaultBlockMax = 512;

  localparam logic [DevAddrW-1:0]    DevAddrReset    = 4'd8;
  localparam logic [BlockBytesW-1:0] BlockBytesReset = 10'd512;

  // Configuration register indexes.
  localparam int unsigned CfgIndexW = 2;
  localparam logic [CfgIndexW-1:0] CFG_DEV_ADDR    = 2'd0;
  localparam logic [CfgIndexW-1:0] CFG_BLOCK_BYTES = 2'd1;

  // Command nibbles of the address byte.
  localparam logic [3:0] CMD_LISTEN = 4'h2;
  localparam logic [3:0] CMD_TALK   = 4'h4;

  // Addressed role codes.
  localparam logic [1:0] ROLE_NONE   = 2'd0;
  localparam logic [1:0] ROLE_LISTEN = 2'd1;
  localparam logic [1:0] ROLE_TALK   = 2'd2;

  // Handshake phases.
  typedef enum logic [3:0] {
    PH_IDLE         = 4'd0,
    PH_ADDR_DAV     = 4'd1,
    PH_ADDR_RELEASE = 4'd2,
    PH_ATN_HIGH     = 4'd3,
    PH_LSN_DAV      = 4'd4,
    PH_LSN_RELEASE  = 4'd5,
    PH_LSN_FINAL    = 4'd6,
    PH_TLK_IDLE     = 4'd7,
    PH_TLK_NRFD     = 4'd8,
    PH_TLK_NDAC     = 4'd9
  } phase_e;

  // Open-collector line drives, 1 pulls the line low.
  typedef struct packed {
    logic eoi;
    logic dav;
    logic nrfd;
    logic ndac;
  } drives_t;

  // One bus sample plus the host's offered byte.
  typedef struct packed {
    logic       atn_line;
    logic       dav_line;
    logic       nrfd_line;
    logic       ndac_line;
    logic       eoi_line;
    logic [7:0] bus_data;
    logic       tx_valid;
    logic [7:0] tx_byte;
    logic       tx_last;
  } gpibdh_in_t;

  // Result of one sample.
  typedef struct packed {
    logic       ndac_drive_low;
    logic       nrfd_drive_low;
    logic       dav_drive_low;
    logic       eoi_drive_low;
    logic [7:0] data_drive;
    logic       data_enable;
    logic       rx_valid;
    logic [7:0] rx_byte;
    logic       rx_end;
    logic       block_end;
    logic [1:0] role;
    logic       tx_ready;
  } gpibdh_out_t;

  // Configuration write.
  typedef struct packed {
    logic [CfgIndexW-1:0]   index;
    logic [BlockBytesW-1:0] value;
  } gpibdh_cfg_t;

endpackage

@@ rtl/gpibdh_chan_if.sv @@
// Valid/ready channel interface used for the sample, result and
// configuration channels. The payload type is a parameter.
`timescale 1ns / 1ps

interface gpibdh_chan_if #(
  parameter type T = logic
) ();

  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);

endinterface

@@ rtl/gpib_device_handshake.sv @@
// Device side of the IEEE-488 three-wire handshake, one bus sample per transfer.
// Depends on gpibdh_pkg and gpibdh_chan_if.
`timescale 1ns / 1ps

// Each transfer on in_ch is one sample of the raw active-low bus lines plus the
// host's offered talker byte; it produces exactly one transfer on out_ch with
// the updated line drives, any received byte and the current role. For each
// accepted sample the phase machine updates and the result lands in the
// output register in the same cycle, and a new sample is accepted every cycle
// as long as that register is empty or being read. Configuration writes on
// cfg_ch are always accepted and should only be issued while no sample is
// pending. The listener flags block_end after block_bytes bytes (0 counts as
// one, capped at BLOCK_MAX and at 1023) and on any byte that arrives with EOI.
module gpib_device_handshake
  import gpibdh_pkg::*;
#(
  parameter int unsigned BLOCK_MAX = DefaultBlockMax
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  gpibdh_chan_if.sink     in_ch,
  gpibdh_chan_if.source   out_ch,
  gpibdh_chan_if.sink     cfg_ch
);

  // Largest limit the block counter can reach with a 10-bit register.
  localparam int unsigned LimCap = (BLOCK_MAX < 1023) ? BLOCK_MAX : 1023;
  localparam logic [BlockBytesW-1:0] LimCapV = BlockBytesW'(LimCap);

  gpibdh_in_t  smp;
  gpibdh_out_t res;
  logic        in_fire;

  logic [DevAddrW-1:0]    dev_addr_q;
  logic [BlockBytesW-1:0] block_bytes_q;

  phase_e                 phase_q, phase_d;
  logic [1:0]             role_q, role_d;
  drives_t                drives_q, drives_d;
  logic [BlockBytesW-1:0] count_q, count_d;
  logic [7:0]             held_byte_q, held_byte_d;
  logic                   held_last_q, held_last_d;

  logic                   out_valid_q;
  gpibdh_out_t            out_data_q;

  logic [BlockBytesW-1:0] bb_eff;
  logic [BlockBytesW-1:0] block_lim;
  logic [BlockBytesW-1:0] count_inc;
  logic [7:0]             cmd;
  logic                   addr_hit;

  assign smp     = in_ch.data;
  assign in_ch.ready = !out_valid_q || out_ch.ready;
  assign in_fire = in_ch.valid && in_ch.ready;

  // Configuration registers; writes to unknown indexes are dropped.
  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dev_addr_q    <= DevAddrReset;
      block_bytes_q <= BlockBytesReset;
    end else if (cfg_ch.valid) begin
      if (cfg_ch.data.index == CFG_DEV_ADDR) begin
        dev_addr_q <= cfg_ch.data.value[DevAddrW-1:0];
      end else if (cfg_ch.data.index == CFG_BLOCK_BYTES) begin
        block_bytes_q <= cfg_ch.data.value;
      end
    end
  end

  // Effective block length and the address byte decode.
  assign bb_eff    = (block_bytes_q == '0) ? BlockBytesW'(1) : block_bytes_q;
  assign block_lim = (bb_eff > LimCapV) ? LimCapV : bb_eff;
  assign count_inc = count_q + BlockBytesW'(1);
  assign cmd       = ~smp.bus_data;
  assign addr_hit  = (cmd[3:0] == dev_addr_q) &&
                     ((cmd[7:4] == CMD_LISTEN) || (cmd[7:4] == CMD_TALK));

  // Phase machine: next state and the result of this sample.
  always_comb begin
    phase_d     = phase_q;
    role_d      = role_q;
    drives_d    = drives_q;
    count_d     = count_q;
    held_byte_d = held_byte_q;
    held_last_d = held_last_q;
    res         = '0;
    res.tx_ready = (phase_q == PH_TLK_IDLE);

    unique case (phase_q)
      PH_ADDR_DAV: begin
        drives_d = '{eoi: 1'b0, dav: 1'b0, nrfd: 1'b0, ndac: 1'b1};
        if (!smp.dav_line) begin
          if (addr_hit) begin
            role_d   = (cmd[7:4] == CMD_LISTEN) ? ROLE_LISTEN : ROLE_TALK;
            drives_d = '{eoi: 1'b0, dav: 1'b0, nrfd: 1'b1, ndac: 1'b0};
            phase_d  = PH_ADDR_RELEASE;
          end else begin
            role_d   = ROLE_NONE;
            drives_d = '0;
            phase_d  = PH_ATN_HIGH;
          end
        end
      end
      PH_ADDR_RELEASE: begin
        if (smp.dav_line) begin
          if (role_q == ROLE_LISTEN) begin
            drives_d = '{eoi: 1'b0, dav: 1'b0, nrfd: 1'b0, ndac: 1'b1};
            count_d  = '0;
            phase_d  = PH_LSN_DAV;
          end else begin
            drives_d = '0;
            phase_d  = PH_TLK_IDLE;
          end
        end
      end
      PH_ATN_HIGH: begin
        drives_d = '0;
        if (smp.atn_line) begin
          phase_d = PH_IDLE;
        end
      end
      PH_LSN_DAV: begin
        drives_d = '{eoi: 1'b0, dav: 1'b0, nrfd: 1'b0, ndac: 1'b1};
        if (!smp.dav_line) begin
          res.rx_valid = 1'b1;
          res.rx_byte  = ~smp.bus_data;
          res.rx_end   = !smp.eoi_line;
          // Block ends on a full count or on the byte that carries EOI.
          if ((count_inc >= block_lim) || !smp.eoi_line) begin
            res.block_end = 1'b1;
            count_d       = '0;
          end else begin
            count_d = count_inc;
          end
          drives_d = '{eoi: 1'b0, dav: 1'b0, nrfd: 1'b1, ndac: 1'b0};
          phase_d  = smp.eoi_line ? PH_LSN_RELEASE : PH_LSN_FINAL;
        end
      end
      PH_LSN_RELEASE: begin
        if (smp.dav_line) begin
          drives_d = '{eoi: 1'b0, dav: 1'b0, nrfd: 1'b0, ndac: 1'b1};
          phase_d  = PH_LSN_DAV;
        end
      end
      PH_LSN_FINAL: begin
        if (smp.dav_line) begin
          phase_d  = PH_IDLE;
          role_d   = ROLE_NONE;
          drives_d = '0;
        end
      end
      PH_TLK_IDLE: begin
        drives_d = '0;
        if (smp.tx_valid) begin
          held_byte_d = smp.tx_byte;
          held_last_d = smp.tx_last;
          phase_d     = PH_TLK_NRFD;
        end
      end
      PH_TLK_NRFD: begin
        if (smp.nrfd_line) begin
          drives_d = '{eoi: held_last_q, dav: 1'b1, nrfd: 1'b0, ndac: 1'b0};
          phase_d  = PH_TLK_NDAC;
        end
      end
      PH_TLK_NDAC: begin
        if (smp.ndac_line) begin
          drives_d = '0;
          if (held_last_q) begin
            phase_d = PH_IDLE;
            role_d  = ROLE_NONE;
          end else begin
            phase_d = PH_TLK_IDLE;
          end
        end
      end
      // Idle and any unused code wait for ATN low.
      default: begin
        phase_d  = PH_IDLE;
        role_d   = ROLE_NONE;
        drives_d = '0;
        if (!smp.atn_line) begin
          drives_d = '{eoi: 1'b0, dav: 1'b0, nrfd: 1'b0, ndac: 1'b1};
          phase_d  = PH_ADDR_DAV;
        end
      end
    endcase

    res.ndac_drive_low = drives_d.ndac;
    res.nrfd_drive_low = drives_d.nrfd;
    res.dav_drive_low  = drives_d.dav;
    res.eoi_drive_low  = drives_d.eoi;
    res.data_enable    = (phase_d == PH_TLK_NRFD) || (phase_d == PH_TLK_NDAC);
    res.data_drive     = res.data_enable ? ~held_byte_d : 8'h00;
    res.role           = role_d;
  end

  // Handshake state, updated once per accepted sample.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_IDLE;
      role_q      <= ROLE_NONE;
      drives_q    <= '0;
      count_q     <= '0;
      held_byte_q <= '0;
      held_last_q <= 1'b0;
    end else if (in_fire) begin
      phase_q     <= phase_d;
      role_q      <= role_d;
      drives_q    <= drives_d;
      count_q     <= count_d;
      held_byte_q <= held_byte_d;
      held_last_q <= held_last_d;
    end
  end

  // Output register; refilled in the cycle it is read.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_fire) begin
      out_valid_q <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      out_data_q <= res;
    end
  end

  assign out_ch.valid = out_valid_q;
  assign out_ch.data  = out_data_q;

`ifndef SYNTHESIS
  // The data lines are only driven while addressed as talker.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_data_q.data_enable |-> out_data_q.role == ROLE_TALK)
    else $error("data lines driven outside the talker role");

  // A received byte is only presented while addressed as listener.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_data_q.rx_valid |-> out_data_q.role == ROLE_LISTEN)
    else $error("received byte outside the listener role");

  // Listener phases always carry the listener role.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PH_LSN_DAV || phase_q == PH_LSN_RELEASE || phase_q == PH_LSN_FINAL)
      |-> role_q == ROLE_LISTEN)
    else $error("listener phase without listener role");

  // DAV is never pulled together with the listener lines.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_data_q.dav_drive_low
      |-> !out_data_q.ndac_drive_low && !out_data_q.nrfd_drive_low)
    else $error("talker and listener lines driven together");

  // A byte with EOI always closes the current block.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_data_q.rx_end |-> out_data_q.block_end)
    else $error("EOI byte without block end");
`endif

endmodule
